// ----- rtl/text_console_writer_defines.svh -----
// Assertion macros for the text console writer.
// Included by the top level; needs no other file.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text console writer: same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text console writer: next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// No dependencies; used by every module of the block.
`default_nettype none
package tcw_pkg;

  localparam int DEF_ROWS    = 25;
  localparam int DEF_COLUMNS = 80;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0]  NEWLINE_CHAR    = 8'h0a;
  localparam logic [7:0]  BLANK_CHAR      = 8'h20;
  localparam logic [7:0]  RESET_ATTRIBUTE = 8'h0f;
  localparam logic [15:0] RESET_BLANK     = {RESET_ATTRIBUTE, BLANK_CHAR};

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } item_word_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [15:0] cell_data;
  } result_word_t;

  typedef struct packed {
    logic capture;
    logic write_char;
    logic advance_col;
    logic next_row;
    logic home;
    logic sweep_start;
    logic sweep_copy;
    logic sweep_step;
    logic read_cell;
    logic load_result;
    logic result_cell;
  } tcw_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       newline;
    logic       idx_ok;
    logic       last_col;
    logic       last_row;
    logic       sweep_last;
    logic       write_pending;
  } tcw_status_t;

endpackage
`default_nettype wire

// ----- rtl/tcw_ctrl.sv -----
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives the datapath by tcw_cmd_t.
`default_nettype none
module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  output logic             result_valid,
  input  wire logic        result_stall,
  input  wire tcw_status_t sts,
  output tcw_cmd_t         cmd
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // start a scroll sweep
  function automatic tcw_cmd_t with_scroll(input tcw_cmd_t c);
    tcw_cmd_t r;
    r = c;
    r.sweep_start = 1'b1;
    r.sweep_copy  = 1'b1;
    return r;
  endfunction

  always_comb begin
    cmd        = '0;
    state_next = state;
    item_stall = 1'b1;
    case (state)
      S_INIT: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FINISH;
        case (sts.op)
          OP_PUT: begin
            if (sts.newline) begin
              cmd.next_row = 1'b1;
              if (sts.last_row) begin
                cmd        = with_scroll(cmd);
                state_next = S_SWEEP;
              end
            end else begin
              cmd.write_char = 1'b1;
              if (sts.last_col) begin
                cmd.next_row = 1'b1;
                if (sts.last_row) begin
                  cmd        = with_scroll(cmd);
                  state_next = S_SWEEP;
                end
              end else begin
                cmd.advance_col = 1'b1;
              end
            end
          end
          OP_CLEAR: begin
            cmd.home        = 1'b1;
            cmd.sweep_start = 1'b1;
            state_next      = S_SWEEP;
          end
          OP_READ: cmd.read_cell = 1'b1;
          default: state_next = S_FINISH;
        endcase
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!result_valid || !result_stall) begin
          cmd.load_result = 1'b1;
          cmd.result_cell = (sts.op == OP_READ) && sts.idx_ok;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tcw_datapath.sv -----
// Datapath of the text console writer: screen memory, cursor, sweep engine.
// Depends on tcw_pkg; commanded by tcw_ctrl.
`default_nettype none
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int ROWS    = DEF_ROWS,
  parameter int COLUMNS = DEF_COLUMNS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire item_word_t  item,
  input  wire logic [7:0]  attribute,
  input  wire tcw_cmd_t    cmd,
  output tcw_status_t      sts,
  output result_word_t     result
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLUMNS);
  localparam int IW         = (AW > 11) ? AW : 11;
  localparam int COPY_END   = CELL_COUNT - COLUMNS;

  logic [15:0]   mem [CELL_COUNT];
  logic [15:0]   rd_data;

  logic [1:0]    op_q;
  logic [7:0]    char_q;
  logic [AW-1:0] idx_q;
  logic          idx_ok_q;

  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [AW-1:0] row_base;

  logic [AW-1:0] sp;
  logic          sweep_copy_q;
  logic [15:0]   blank_cell;
  logic          wr_pending;
  logic [AW-1:0] wr_addr;
  logic          wr_from_mem;

  logic [IW:0]   idx_ext;
  logic          copy_now;
  logic [AW-1:0] src_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;

  assign idx_ext  = (IW + 1)'(item.cell_index);
  assign copy_now = sweep_copy_q && ({1'b0, sp} < (AW + 1)'(COPY_END));
  assign src_addr = AW'({1'b0, sp} + (AW + 1)'(COLUMNS));

  // sweep writes land in the cycle after their reads; never overlap a character write
  assign we    = wr_pending || cmd.write_char;
  assign waddr = wr_pending ? wr_addr : (row_base + AW'(col));
  assign wdata = wr_pending ? (wr_from_mem ? rd_data : blank_cell) : {attribute, char_q};
  assign re    = cmd.read_cell || (cmd.sweep_step && copy_now);
  assign raddr = cmd.read_cell ? idx_q : src_addr;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= item.opcode;
      char_q   <= item.char_code;
      idx_q    <= AW'(item.cell_index);
      idx_ok_q <= idx_ext < (IW + 1)'(CELL_COUNT);
    end
    if (cmd.load_result) begin
      result.cursor_row    <= 5'(row);
      result.cursor_column <= 7'(col);
      result.cell_data     <= cmd.result_cell ? rd_data : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row          <= '0;
      col          <= '0;
      row_base     <= '0;
      sp           <= '0;
      sweep_copy_q <= 1'b0;
      blank_cell   <= RESET_BLANK;
      wr_pending   <= 1'b0;
      wr_addr      <= '0;
      wr_from_mem  <= 1'b0;
    end else begin
      if (cmd.home) begin
        row      <= '0;
        col      <= '0;
        row_base <= '0;
      end else if (cmd.next_row) begin
        col <= '0;
        if (!sts.last_row) begin
          row      <= row + RW'(1);
          row_base <= row_base + AW'(COLUMNS);
        end
      end else if (cmd.advance_col) begin
        col <= col + CW'(1);
      end

      if (cmd.sweep_start) begin
        sp           <= '0;
        sweep_copy_q <= cmd.sweep_copy;
        blank_cell   <= {attribute, BLANK_CHAR};
      end

      wr_pending <= cmd.sweep_step;
      if (cmd.sweep_step) begin
        wr_addr     <= sp;
        wr_from_mem <= copy_now;
        sp          <= sp + AW'(1);
      end
    end
  end

  always_comb begin
    sts               = '0;
    sts.op            = op_q;
    sts.newline       = (char_q == NEWLINE_CHAR);
    sts.idx_ok        = idx_ok_q;
    sts.last_col      = (col == CW'(COLUMNS - 1));
    sts.last_row      = (row == RW'(ROWS - 1));
    sts.sweep_last    = (sp == AW'(CELL_COUNT - 1));
    sts.write_pending = wr_pending;
  end

endmodule
`default_nettype wire

// ----- rtl/text_console_writer.sv -----
// Text console writer: top level with configuration port and assertions.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath and text_console_writer_defines.svh.
//
// Usage:
//  - item channel (item_valid / item_stall / item) carries one command word:
//    put character, clear screen or read cell. A word is taken when
//    item_valid is high and item_stall is low.
//  - result channel (result_valid / result_stall / result) returns one word
//    per command: the cursor after the command and, for a read, the cell.
//  - one command executes at a time. Put and read run through the execute and
//    finish states; the result is loaded in finish, then the next word is taken
//    in idle. Clear, and a put that scrolls, add a sweep of the screen memory
//    through its single write port, one cell a cycle (a scroll copies one row up,
//    then blanks the bottom row; a clear blanks every cell).
//  - reset: a clearing pass writes a blank (space, attribute 0x0f) to each of
//    the ROWS*COLUMNS cells, one a cycle; item_stall stays high until it ends.
//    The APB port is served throughout.
//  - a stalled result is held in its output register; the next command is
//    still taken and runs, and waits only to hand over its own result.
//  - user writes text_attribute (APB byte address 0) only while idle; unenforced.
`default_nettype none
`include "text_console_writer_defines.svh"
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int ROWS    = DEF_ROWS,
  parameter int COLUMNS = DEF_COLUMNS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire item_word_t   item,
  output logic              result_valid,
  input  wire logic         result_stall,
  output result_word_t      result,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

  logic [7:0]  attribute;
  tcw_cmd_t    cmd;
  tcw_status_t sts;

  // register file: a single attribute byte, word index in paddr[2]
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_ATTRIBUTE) ? {24'h000000, attribute} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= RESET_ATTRIBUTE;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_ATTRIBUTE)) begin
      attribute <= pwdata[7:0];
    end
  end

  tcw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  tcw_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .attribute (attribute),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

  // hold off new words while the memory is being swept
  `ASSERT_IMPLY(a_no_accept_in_sweep, clk, rst, cmd.sweep_step, item_stall)
  // a character write must never collide with a lagging sweep write
  `ASSERT_IMPLY(a_write_port_free, clk, rst, cmd.write_char, !sts.write_pending)
  // a result is loaded only into a free or draining output register
  `ASSERT_IMPLY(a_result_slot, clk, rst, cmd.load_result, !result_valid || !result_stall)
  // an accepted word keeps the block busy in the next cycle
  `ASSERT_NEXT(a_accept_busy, clk, rst, item_valid && !item_stall, item_stall)

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking bench for the text console writer: directed table, then random
// command words, checked against a behavioural screen and cursor model.
// Depends on tcw_pkg and the text_console_writer RTL only.
`timescale 1ns / 1ps
module tb;
  import tcw_pkg::*;

  localparam int ROWS    = DEF_ROWS;
  localparam int COLUMNS = DEF_COLUMNS;
  localparam int CELLS   = ROWS * COLUMNS;

  // Opcode three has no name in the package; the block must ignore it.
  localparam logic [1:0] OP_SPARE = 2'd3;
  // Byte address of the text_attribute register.
  localparam logic [2:0] ATTR_ADDR = 3'd0;

  localparam int SEG_COUNT = 6;
  localparam int SEG_WORDS = 17;
  localparam int ROW_COUNT = 23;

  logic         clk;
  logic         rst;
  logic         item_valid;
  logic         item_stall;
  item_word_t   item;
  logic         result_valid;
  logic         result_stall;
  result_word_t result;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  text_console_writer u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Shadow copy of the screen, the cursor and the attribute register.
  logic [15:0] screen_model [0:CELLS-1];
  int          cur_row;
  int          cur_col;
  logic [7:0]  attr_model;

  // Cursor reports still owed by the block, oldest first.
  result_word_t pending_reports [$];

  int fail_count = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  bit hold_request = 1'b0;

  // One directed step: a command word, how many times to send it, and the
  // report typed in by hand where it is obvious (only for single words).
  typedef struct packed {
    item_word_t   cmd;
    logic [6:0]   reps;
    logic         typed;
    result_word_t want;
  } stim_row_t;

  stim_row_t directed_table [0:ROW_COUNT-1] = '{
    // fresh screen: every cell blank in the reset attribute
    '{'{OP_READ,  8'h00, 11'd0},    7'd1,  1'b1, '{5'd0,  7'd0, 16'h0f20}},
    '{'{OP_READ,  8'h00, 11'd1999}, 7'd1,  1'b1, '{5'd0,  7'd0, 16'h0f20}},
    // reads off the end of the screen return zero
    '{'{OP_READ,  8'h00, 11'd2000}, 7'd1,  1'b1, '{5'd0,  7'd0, 16'h0000}},
    '{'{OP_READ,  8'hff, 11'd2047}, 7'd1,  1'b1, '{5'd0,  7'd0, 16'h0000}},
    // unused opcode changes nothing
    '{'{OP_SPARE, 8'hff, 11'h7ff},  7'd1,  1'b1, '{5'd0,  7'd0, 16'h0000}},
    '{'{OP_PUT,   8'h41, 11'd0},    7'd1,  1'b1, '{5'd0,  7'd1, 16'h0000}},
    '{'{OP_PUT,   8'h00, 11'h7ff},  7'd1,  1'b1, '{5'd0,  7'd2, 16'h0000}},
    '{'{OP_PUT,   8'hff, 11'd0},    7'd1,  1'b1, '{5'd0,  7'd3, 16'h0000}},
    '{'{OP_READ,  8'h00, 11'd0},    7'd1,  1'b1, '{5'd0,  7'd3, 16'h0f41}},
    // newline writes nothing and drops to the next row
    '{'{OP_PUT,   8'h0a, 11'd0},    7'd1,  1'b1, '{5'd1,  7'd0, 16'h0000}},
    // fill row 1 up to the last column, then wrap
    '{'{OP_PUT,   8'h78, 11'd0},    7'd79, 1'b0, '0},
    '{'{OP_PUT,   8'h7e, 11'd0},    7'd1,  1'b1, '{5'd2,  7'd0, 16'h0000}},
    '{'{OP_READ,  8'h00, 11'd159},  7'd1,  1'b1, '{5'd2,  7'd0, 16'h0f7e}},
    // walk down to the bottom row, then scroll with a newline
    '{'{OP_PUT,   8'h0a, 11'd0},    7'd22, 1'b0, '0},
    '{'{OP_PUT,   8'h5a, 11'd0},    7'd1,  1'b1, '{5'd24, 7'd1, 16'h0000}},
    '{'{OP_PUT,   8'h0a, 11'd0},    7'd1,  1'b1, '{5'd24, 7'd0, 16'h0000}},
    '{'{OP_READ,  8'h00, 11'd1840}, 7'd1,  1'b1, '{5'd24, 7'd0, 16'h0f5a}},
    '{'{OP_READ,  8'h00, 11'd1920}, 7'd1,  1'b1, '{5'd24, 7'd0, 16'h0f20}},
    // a full bottom row wraps at the last column and scrolls
    '{'{OP_PUT,   8'h71, 11'd0},    7'd80, 1'b0, '0},
    '{'{OP_READ,  8'h00, 11'd1919}, 7'd1,  1'b1, '{5'd24, 7'd0, 16'h0f71}},
    '{'{OP_READ,  8'h00, 11'd1999}, 7'd1,  1'b1, '{5'd24, 7'd0, 16'h0f20}},
    '{'{OP_CLEAR, 8'h0a, 11'h7ff},  7'd1,  1'b1, '{5'd0,  7'd0, 16'h0000}},
    '{'{OP_READ,  8'h00, 11'd1000}, 7'd1,  1'b1, '{5'd0,  7'd0, 16'h0f20}}
  };

  // Move the cursor to column 0 of the next row; past the bottom row, shift
  // the screen up and blank the bottom row in the current attribute.
  function automatic void feed_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = {attr_model, BLANK_CHAR};
      cur_row = ROWS - 1;
    end
  endfunction

  // Apply one command word to the shadow console and return its report.
  function automatic result_word_t step_console(item_word_t w);
    result_word_t r;
    r = '0;
    case (w.opcode)
      OP_PUT: begin
        if (w.char_code == NEWLINE_CHAR) begin
          feed_line();
        end else begin
          screen_model[cur_row * COLUMNS + cur_col] = {attr_model, w.char_code};
          cur_col++;
          if (cur_col >= COLUMNS) feed_line();
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = {attr_model, BLANK_CHAR};
        cur_row = 0;
        cur_col = 0;
      end
      OP_READ: begin
        if (w.cell_index < CELLS) r.cell_data = screen_model[w.cell_index];
      end
      default: ;
    endcase
    r.cursor_row    = cur_row[4:0];
    r.cursor_column = cur_col[6:0];
    return r;
  endfunction

  // Offer one word, entered and left at a falling edge. Valid stays high
  // into the next call unless that call starts with an idle gap.
  task automatic send_word(input item_word_t w, input bit typed, input result_word_t want);
    result_word_t got;
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item       = w;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    got = step_console(w);
    pending_reports.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // Write text_attribute over APB: setup cycle, then access cycle.
  task automatic write_text_attribute(input logic [7:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ATTR_ADDR;
    pwdata  = {24'd0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    attr_model = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: stall at random, or hold off for a long counted stretch when
  // asked, so the block backs up and stalls its input.
  initial begin
    int hold_left;
    hold_left    = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = 400;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        result_stall = 1'b1;
        hold_left--;
      end else begin
        result_stall = ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  // Compare each accepted result word with the oldest outstanding report.
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result word %h", result);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (result.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, result.cursor_row);
          fail_count++;
        end
        if (result.cursor_column !== want.cursor_column) begin
          $error("cursor_column: expected %0d, got %0d",
                 want.cursor_column, result.cursor_column);
          fail_count++;
        end
        if (result.cell_data !== want.cell_data) begin
          $error("cell_data: expected %h, got %h", want.cell_data, result.cell_data);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random segments.
  initial begin
    item_word_t w;
    stim_row_t  row;
    int         line_left;
    int         pick;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    attr_model = RESET_ATTRIBUTE;
    cur_row    = 0;
    cur_col    = 0;
    line_left  = 0;
    for (int i = 0; i < CELLS; i++) screen_model[i] = RESET_BLANK;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Sender idles often, receiver very often, for the directed table.
    sender_idle_pct   = 29;
    receiver_idle_pct = 87;
    write_text_attribute(RESET_ATTRIBUTE);
    for (int k = 0; k < ROW_COUNT; k++) begin
      row = directed_table[k];
      repeat (row.reps) send_word(row.cmd, row.typed, row.want);
    end

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      // Drain before touching the register: the block must be idle.
      item_valid = 1'b0;
      while (pending_reports.size() != 0) @(negedge clk);
      case (seg)
        0: write_text_attribute(8'h00);
        1: write_text_attribute(8'hff);
        4: write_text_attribute(8'h80);
        default: write_text_attribute(8'($urandom_range(255)));
      endcase
      case (seg / 2)
        0: begin
          sender_idle_pct   = 29;
          receiver_idle_pct = 87;
        end
        1: begin
          sender_idle_pct   = 87;
          receiver_idle_pct = 29;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      // Back the block up while words keep coming.
      if (seg == 4) hold_request = 1'b1;

      for (int k = 0; k < SEG_WORDS; k++) begin
        // Pause the sender once until every report has come back.
        if (seg == 2 && k == SEG_WORDS / 2) begin
          item_valid = 1'b0;
          while (pending_reports.size() != 0) @(negedge clk);
        end
        // Mostly lines of text ending in a newline; some reads, rare clears,
        // the odd unused opcode and stray newlines as noise.
        pick         = $urandom_range(99);
        w.char_code  = 8'($urandom_range(255));
        w.cell_index = 11'($urandom_range(2047));
        if (pick < 8) begin
          w.opcode = OP_READ;
          if ($urandom_range(9) != 0) w.cell_index = 11'($urandom_range(CELLS - 1));
        end else if (pick < 9) begin
          w.opcode = OP_CLEAR;
        end else if (pick < 10) begin
          w.opcode = OP_SPARE;
        end else begin
          w.opcode = OP_PUT;
          if (pick < 14 || line_left == 0) begin
            w.char_code = NEWLINE_CHAR;
            pick = $urandom_range(9);
            if (pick < 6) line_left = $urandom_range(8);
            else if (pick < 9) line_left = $urandom_range(70, 9);
            else line_left = $urandom_range(85, 75);
          end else begin
            if (w.char_code == NEWLINE_CHAR) w.char_code = BLANK_CHAR;
            line_left--;
          end
        end
        send_word(w, 1'b0, '0);
      end
    end

    item_valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    // Allow for any stray word after the last report.
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
